[src/ffba_pkg.sv]
// shared types and constants for the first-fit block allocator
`timescale 1ns / 1ps
package ffba_pkg;

	localparam int MAX_BLOCKS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 16;
	localparam int COUNT_BITS     = 6;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  block_index;
		logic [15:0] size_value;
		logic        last_file;
	} req_t;

	typedef struct packed {
		logic [5:0]  granted_block;
		logic        fits;
		logic [15:0] fragment;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        is_alloc;
		logic        slot_ok;
		logic [4:0]  slot;
		logic [15:0] size;
		logic        last;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_SCAN
	} back_state_t;

endpackage

[src/first_fit_block_allocator_core.sv]
// top level of the first-fit block allocator
//
//  channel   ports                 direction  handshake
//  request   start, busy, req      in         taken when start high and busy low
//  result    done, rsp             out        one-cycle strobe on done, no stall
//  config    cfg_we, cfg_wdata     in         block_count written when cfg_we high
//
// a load is popped in the idle state and writes the table in the exec state
// an allocate holds the back for a scan over up to min(block_count, MAX_BLOCKS) entries,
// one entry per cycle, of the size ram (one read port, registered read)
// reset clears the used map, the queue and block_count; the size table is not cleared
// busy rises only while the intake register waits on a full queue
`timescale 1ns / 1ps
module first_fit_block_allocator_core #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ffba_pkg::req_t                  req,
	output logic                            done,
	output ffba_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [ffba_pkg::COUNT_BITS-1:0] cfg_wdata
);
	import ffba_pkg::*;

	logic [COUNT_BITS-1:0] block_count_q;
	logic                  push;
	cmd_t                  push_data;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	cmd_t                  q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	ffba_front #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	ffba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	ffba_back #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_count (block_count_q),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.done        (done),
		.rsp         (rsp)
	);

endmodule

[src/ffba_ram.sv]
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/ffba_queue.sv]
// short command queue between front and back
`timescale 1ns / 1ps
module ffba_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ffba_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output ffba_pkg::cmd_t pop_data,
	output logic          empty
);
	import ffba_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full     = (count_q == NW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/ffba_front.sv]
// request intake: accepts a word, classifies it and feeds the queue
`timescale 1ns / 1ps
module ffba_front #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ffba_pkg::req_t req,
	output logic           busy,
	output logic           push,
	output ffba_pkg::cmd_t push_data,
	input  logic           q_full
);
	import ffba_pkg::*;

	cmd_t cmd_s1;
	logic vld_s1;
	cmd_t cmd_d;

	assign busy      = vld_s1 && q_full;
	assign push      = vld_s1 && !q_full;
	assign push_data = cmd_s1;

	always_comb begin
		cmd_d.is_alloc = (req.req_type == REQ_ALLOC);
		// loads beyond the table are dropped but still carry the last mark
		cmd_d.slot_ok  = (32'(req.block_index) < MAX_BLOCKS);
		cmd_d.slot     = req.block_index;
		cmd_d.size     = req.size_value;
		cmd_d.last     = req.last_file;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (start && !busy) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

endmodule

[src/ffba_back.sv]
// execution side: size table writes, first-fit scan, used map and result
`timescale 1ns / 1ps
module ffba_back #(
	parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = ffba_pkg::SIZE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [ffba_pkg::COUNT_BITS-1:0]     block_count,
	input  logic                                q_empty,
	input  ffba_pkg::cmd_t                      q_data,
	output logic                                q_pop,
	output logic                                done,
	output ffba_pkg::rsp_t                      rsp
);
	import ffba_pkg::*;

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int LW = (CW > COUNT_BITS) ? CW : COUNT_BITS;

	back_state_t     state_q, state_d;
	cmd_t            cur_q;
	logic [CW-1:0]   rd_idx_q;
	logic            cmp_vld_s1;
	logic [IW-1:0]   cmp_idx_s1;
	logic [MAX_BLOCKS-1:0] used_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic [LW-1:0]        cnt_ext;
	logic [CW-1:0]        limit;
	logic [SIZE_BITS-1:0] fsize;
	logic [SIZE_BITS-1:0] rdata;
	logic                 hit;
	logic                 scan_end;
	logic                 ram_we;
	logic                 ram_re;
	logic                 emit;
	logic                 finish;

	assign cnt_ext = LW'(block_count);
	assign limit   = (cnt_ext > LW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cnt_ext);
	assign fsize   = SIZE_BITS'(cur_q.size);

	ffba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_BLOCKS)
	) u_sizes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(cur_q.slot)),
		.wdata (SIZE_BITS'(cur_q.size)),
		.re    (ram_re),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rdata)
	);

	// compare stage sees the entry read in the previous cycle
	assign hit      = cmp_vld_s1 && !used_q[cmp_idx_s1] && (rdata >= fsize);
	assign scan_end = hit || (cmp_vld_s1 && (CW'(cmp_idx_s1) + CW'(1) == limit));

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_EXEC;
			end
			B_EXEC: begin
				if (cur_q.is_alloc && limit != '0) state_d = B_SCAN;
				else                               state_d = B_IDLE;
			end
			B_SCAN: begin
				if (scan_end) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = 1'b0;
		ram_we = 1'b0;
		ram_re = 1'b0;
		emit   = 1'b0;
		finish = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_pop = !q_empty;
			end
			B_EXEC: begin
				ram_we = !cur_q.is_alloc && cur_q.slot_ok;
				emit   = cur_q.is_alloc && (limit == '0);
				finish = !cur_q.is_alloc || (limit == '0);
			end
			B_SCAN: begin
				ram_re = (rd_idx_q < limit) && !scan_end;
				emit   = scan_end;
				finish = scan_end;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		cmp_idx_s1 <= rd_idx_q[IW-1:0];
		if (emit) begin
			if (hit) begin
				rsp_q.granted_block <= 6'(cmp_idx_s1) + 6'd1;
				rsp_q.fits          <= 1'b1;
				rsp_q.fragment      <= 16'(rdata - fsize);
			end else begin
				rsp_q.granted_block <= '0;
				rsp_q.fits          <= 1'b0;
				rsp_q.fragment      <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			used_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= emit;
			cmp_vld_s1 <= ram_re;
			if (state_q == B_EXEC) begin
				rd_idx_q <= '0;
			end else if (ram_re) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			// last mark clears after the word is served
			if (finish && cur_q.last) begin
				used_q <= '0;
			end else if (state_q == B_SCAN && hit) begin
				used_q[cmp_idx_s1] <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !rsp_q.fits) |-> (rsp_q.granted_block == '0 && rsp_q.fragment == '0))
		else $error("no-fit result carries nonzero fields");

	a_fit_block: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.fits) |-> (rsp_q.granted_block != '0))
		else $error("fit result without block number");

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> (state_q == B_SCAN))
		else $error("compare stage live outside scan");

endmodule
